[hdl/waypoint_velocity_command_core_macros.svh]
// Assertion helpers used by waypoint_velocity_command_core.sv.
`ifndef WAYPOINT_VELOCITY_COMMAND_CORE_MACROS_SVH
`define WAYPOINT_VELOCITY_COMMAND_CORE_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define WVC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("wvc assertion failed");

// Antecedent implies consequent in the following cycle.
`define WVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wvc assertion failed");

`endif

[hdl/wvc_pkg.sv]
package wvc_pkg;

  // Stages in each CORDIC chain (8 to 32)
  localparam int CORDIC_STAGES = 16;

  // Datapath widths
  localparam int POS_W   = 32;
  localparam int QUAT_W  = 16;
  localparam int D_W     = 33;   // goal minus position
  localparam int P_W     = 32;   // quaternion products
  localparam int V_W     = 36;   // yaw CORDIC driving vector
  localparam int W_W     = 42;   // offsets with guard bits
  localparam int GUARD   = 6;
  localparam int B_W     = 35;   // body-frame offsets
  localparam int M_W     = 34;   // offset magnitudes
  localparam int X_W     = 54;   // bearing CORDIC vector
  localparam int ANG_W   = 36;   // angle, Q32 radians
  localparam int SPD_W   = 21;
  localparam int BAND_W  = 23;
  localparam int VEL_W   = 22;
  localparam int NUM_W   = M_W + SPD_W;
  localparam int Q_W     = SPD_W;
  localparam int CMP_W   = 40;
  localparam int KG_W    = 25;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 32;

  localparam logic signed [KG_W-1:0]  INV_GAIN_Q24   = KG_W'(10188014);
  localparam logic signed [ANG_W-1:0] PI_Q32         = ANG_W'(64'd13493037705);
  localparam longint                  QUARTER_PI_Q32 = 64'd3373259426;

  localparam logic [SPD_W-1:0]  SPEED_RESET = SPD_W'(26214);
  localparam logic [BAND_W-1:0] BAND_RESET  = BAND_W'(13107);

  typedef enum logic [IDX_W-1:0] {
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_GOAL_Z,
    REG_SPEED,
    REG_BAND
  } cfg_reg_t;

  // Yaw rotation stage contents
  typedef struct packed {
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
    logic signed [W_W-1:0] wx;
    logic signed [W_W-1:0] wy;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
    logic                  degen;
  } yaw_t;

  // Bearing stage contents
  typedef struct packed {
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic signed [ANG_W-1:0] ang;
    logic signed [B_W-1:0]   bx;
    logic signed [B_W-1:0]   by;
    logic signed [B_W-1:0]   bz;
    logic [M_W-1:0]          mx;
    logic                    nz;
    logic                    fin;
  } brg_t;

  // Side data carried along the divider
  typedef struct packed {
    logic [2:0]              neg;
    logic                    zero;
    logic                    fin;
    logic signed [VEL_W-1:0] yr;
  } div_side_t;

  // shift-subtract quotient of two constants, elaboration only
  function automatic longint unsigned udiv_c(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32, rounded; series in Q62, elaboration only
  function automatic longint atan_q32(int i);
    longint sum;
    longint t;
    longint unsigned k;
    int e;
    sum = 0;
    k = 0;
    e = 62 - i;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    while (e >= 0) begin
      t = longint'(udiv_c(64'd1 << e, 2 * k + 1));
      sum = k[0] ? sum - t : sum + t;
      k = k + 1;
      e = e - 2 * i;
    end
    return (sum + (64'sd1 <<< 29)) >>> 30;
  endfunction

endpackage

[hdl/wvc_div.sv]
// Three-lane restoring divider, one quotient bit per stage
module wvc_div import wvc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][NUM_W-1:0]      num,
  input  logic [M_W-1:0]             mx,
  input  div_side_t                  side_in,
  output logic                       out_valid,
  output logic [2:0][Q_W-1:0]        quo,
  output div_side_t                  side_out
);

  logic [Q_W:0]              v;
  logic [2:0][NUM_W-1:0]     rem [0:Q_W];
  logic [2:0][Q_W-1:0]       qa  [0:Q_W];
  logic [M_W-1:0]            dv  [0:Q_W];
  div_side_t                 sd  [0:Q_W];

  assign v[0]   = in_valid;
  assign rem[0] = num;
  assign qa[0]  = '0;
  assign dv[0]  = mx;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int K = Q_W - 1 - j;
    logic [2:0][NUM_W-1:0] rem_next;
    logic [2:0][Q_W-1:0]   qa_next;

    // trial subtract of the shifted divisor in each lane
    always_comb begin
      logic [NUM_W-1:0] dsh;
      logic [NUM_W:0]   trial;
      rem_next = rem[j];
      qa_next  = qa[j];
      dsh      = NUM_W'(dv[j]) << K;
      for (int l = 0; l < 3; l++) begin
        trial = {1'b0, rem[j][l]} - {1'b0, dsh};
        rem_next[l]   = trial[NUM_W] ? rem[j][l] : trial[NUM_W-1:0];
        qa_next[l][K] = ~trial[NUM_W];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= rem_next;
        qa[j+1]  <= qa_next;
        dv[j+1]  <= dv[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign out_valid = v[Q_W];
  assign quo       = qa[Q_W];
  assign side_out  = sd[Q_W];

endmodule

[hdl/waypoint_velocity_command_core.sv]
// Throughput: one pose sample per cycle; the whole pipeline advances together and
// holds when the output register is full and stalled.
// Reset (rst, synchronous): clears all valid bits, goals to 0, speed to 0.4, band to 0.2.
`include "waypoint_velocity_command_core_macros.svh"

module waypoint_velocity_command_core import wvc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // pose input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [QUAT_W-1:0] quat_w,
  input  logic signed [QUAT_W-1:0] quat_x,
  input  logic signed [QUAT_W-1:0] quat_y,
  input  logic signed [QUAT_W-1:0] quat_z,
  // command output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VEL_W-1:0]  vel_x,
  output logic signed [VEL_W-1:0]  vel_y,
  output logic signed [VEL_W-1:0]  vel_z,
  output logic signed [VEL_W-1:0]  yaw_rate,
  output logic                     finished
);

  localparam int N = CORDIC_STAGES;

  logic signed [POS_W-1:0] goal_x, goal_y, goal_z;
  logic [SPD_W-1:0]        cruise_speed;
  logic [BAND_W-1:0]       arrival_band;
  logic                    en;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x       <= '0;
      goal_y       <= '0;
      goal_z       <= '0;
      cruise_speed <= SPEED_RESET;
      arrival_band <= BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GOAL_X: goal_x       <= cfg_data;
        REG_GOAL_Y: goal_y       <= cfg_data;
        REG_GOAL_Z: goal_z       <= cfg_data;
        REG_SPEED:  cruise_speed <= cfg_data[SPD_W-1:0];
        REG_BAND:   arrival_band <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: offsets and quaternion products
  logic                  s1_v;
  logic signed [D_W-1:0] s1_dx, s1_dy, s1_dz;
  logic signed [P_W-1:0] p_wz, p_xy, p_yy, p_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx <= D_W'(goal_x) - D_W'(pos_x);
      s1_dy <= D_W'(goal_y) - D_W'(pos_y);
      s1_dz <= D_W'(goal_z) - D_W'(pos_z);
      p_wz  <= quat_w * quat_z;
      p_xy  <= quat_x * quat_y;
      p_yy  <= quat_y * quat_y;
      p_zz  <= quat_z * quat_z;
    end
  end

  // yaw vector and half-plane fold
  yaw_t        yst [0:N];
  logic [N:0]  yv;
  yaw_t        y0_next;

  always_comb begin
    logic signed [V_W-1:0] vx, vy;
    logic signed [W_W-1:0] wx, wy;
    vy = (V_W'(p_wz) + V_W'(p_xy)) <<< 1;
    vx = (V_W'(1) <<< 28) - ((V_W'(p_yy) + V_W'(p_zz)) <<< 1);
    wx = W_W'(s1_dx) <<< GUARD;
    wy = W_W'(s1_dy) <<< GUARD;
    y0_next.degen = (vx == '0) && (vy == '0);
    y0_next.vx = (vx < 0) ? -vx : vx;
    y0_next.vy = (vx < 0) ? -vy : vy;
    y0_next.wx = (vx < 0) ? -wx : wx;
    y0_next.wy = (vx < 0) ? -wy : wy;
    y0_next.dx = s1_dx;
    y0_next.dy = s1_dy;
    y0_next.dz = s1_dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yv[0] <= 1'b0;
    end else if (en) begin
      yv[0] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yst[0] <= y0_next;
    end
  end

  // yaw rotation, one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_yaw
    yaw_t nx;
    always_comb begin
      nx = yst[i];
      if (yst[i].vy > 0) begin
        nx.vx = yst[i].vx + (yst[i].vy >>> i);
        nx.vy = yst[i].vy - (yst[i].vx >>> i);
        nx.wx = yst[i].wx + (yst[i].wy >>> i);
        nx.wy = yst[i].wy - (yst[i].wx >>> i);
      end else begin
        nx.vx = yst[i].vx - (yst[i].vy >>> i);
        nx.vy = yst[i].vy + (yst[i].vx >>> i);
        nx.wx = yst[i].wx - (yst[i].wy >>> i);
        nx.wy = yst[i].wy + (yst[i].wx >>> i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        yv[i+1] <= 1'b0;
      end else if (en) begin
        yv[i+1] <= yv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        yst[i+1] <= nx;
      end
    end
  end

  // gain correction: split multiply, then sum and round
  localparam int LO_W = W_W / 2;
  localparam int HI_W = W_W - LO_W;
  localparam int SUM_W = HI_W + KG_W + LO_W + 2;

  logic                          g1_v, g2_v;
  logic signed [LO_W+KG_W:0]     g1_plx, g1_ply;
  logic signed [HI_W+KG_W-1:0]   g1_phx, g1_phy;
  logic signed [D_W-1:0]         g1_dx, g1_dy, g1_dz;
  logic                          g1_degen;
  logic signed [B_W-1:0]         g2_bx, g2_by, g2_bz;
  logic signed [SUM_W-1:0]       sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_v <= 1'b0;
      g2_v <= 1'b0;
    end else if (en) begin
      g1_v <= yv[N];
      g2_v <= g1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_plx   <= $signed({1'b0, yst[N].wx[LO_W-1:0]}) * INV_GAIN_Q24;
      g1_ply   <= $signed({1'b0, yst[N].wy[LO_W-1:0]}) * INV_GAIN_Q24;
      g1_phx   <= $signed(yst[N].wx[W_W-1:LO_W]) * INV_GAIN_Q24;
      g1_phy   <= $signed(yst[N].wy[W_W-1:LO_W]) * INV_GAIN_Q24;
      g1_dx    <= yst[N].dx;
      g1_dy    <= yst[N].dy;
      g1_dz    <= yst[N].dz;
      g1_degen <= yst[N].degen;
    end
  end

  always_comb begin
    sum_x = ((SUM_W'(g1_phx) <<< LO_W) + SUM_W'(g1_plx) + (SUM_W'(1) <<< (23 + GUARD)))
            >>> (24 + GUARD);
    sum_y = ((SUM_W'(g1_phy) <<< LO_W) + SUM_W'(g1_ply) + (SUM_W'(1) <<< (23 + GUARD)))
            >>> (24 + GUARD);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_bx <= g1_degen ? B_W'(g1_dx) : sum_x[B_W-1:0];
      g2_by <= g1_degen ? B_W'(g1_dy) : sum_y[B_W-1:0];
      g2_bz <= B_W'(g1_dz);
    end
  end

  // arrival test, largest offset, bearing fold
  brg_t        bst [0:N];
  logic [N:0]  bv;
  brg_t        b0_next;

  always_comb begin
    logic signed [B_W-1:0] ax, ay, az;
    logic signed [X_W-1:0] x, y;
    logic [M_W-1:0]        m;
    ax = (g2_bx < 0) ? -g2_bx : g2_bx;
    ay = (g2_by < 0) ? -g2_by : g2_by;
    az = (g2_bz < 0) ? -g2_bz : g2_bz;
    m = ax[M_W-1:0];
    if (ay[M_W-1:0] > m) m = ay[M_W-1:0];
    if (az[M_W-1:0] > m) m = az[M_W-1:0];
    x = X_W'(g2_bx) <<< 16;
    y = X_W'(g2_by) <<< 16;
    b0_next.fin = (ax[M_W-1:0] < M_W'(arrival_band)) && (ay[M_W-1:0] < M_W'(arrival_band))
                  && (az[M_W-1:0] < M_W'(arrival_band));
    b0_next.mx  = m;
    b0_next.nz  = (g2_bx != '0) || (g2_by != '0);
    b0_next.bx  = g2_bx;
    b0_next.by  = g2_by;
    b0_next.bz  = g2_bz;
    b0_next.ang = '0;
    b0_next.x   = x;
    b0_next.y   = y;
    if (x < 0) begin
      b0_next.ang = (y >= 0) ? PI_Q32 : -PI_Q32;
      b0_next.x   = -x;
      b0_next.y   = -y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else if (en) begin
      bv[0] <= g2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bst[0] <= b0_next;
    end
  end

  // bearing CORDIC, vectoring mode
  for (genvar i = 0; i < N; i++) begin : g_brg
    localparam logic signed [ANG_W-1:0] ATAN_I = ANG_W'(atan_q32(i));
    brg_t nx;
    always_comb begin
      nx = bst[i];
      if (bst[i].y > 0) begin
        nx.x   = bst[i].x + (bst[i].y >>> i);
        nx.y   = bst[i].y - (bst[i].x >>> i);
        nx.ang = bst[i].ang + ATAN_I;
      end else begin
        nx.x   = bst[i].x - (bst[i].y >>> i);
        nx.y   = bst[i].y + (bst[i].x >>> i);
        nx.ang = bst[i].ang - ATAN_I;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        bv[i+1] <= 1'b0;
      end else if (en) begin
        bv[i+1] <= bv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        bst[i+1] <= nx;
      end
    end
  end

  // yaw-rate decision and velocity numerators
  logic                   c_v;
  logic [2:0][NUM_W-1:0]  c_num;
  logic [M_W-1:0]         c_mx;
  div_side_t              c_side, c_side_next;
  logic [2:0][M_W-1:0]    mags;

  always_comb begin
    logic signed [ANG_W-1:0] a;
    logic [CMP_W-1:0]        a5, th;
    logic signed [B_W-1:0]   ax, ay, az;
    a  = bst[N].nz ? bst[N].ang : '0;
    a5 = CMP_W'(a < 0 ? -a : a);
    a5 = (a5 << 2) + a5;
    th = CMP_W'(arrival_band) << 16;
    ax = (bst[N].bx < 0) ? -bst[N].bx : bst[N].bx;
    ay = (bst[N].by < 0) ? -bst[N].by : bst[N].by;
    az = (bst[N].bz < 0) ? -bst[N].bz : bst[N].bz;
    mags[0] = ax[M_W-1:0];
    mags[1] = ay[M_W-1:0];
    mags[2] = az[M_W-1:0];
    c_side_next.yr   = '0;
    if (!(a5 < th)) begin
      c_side_next.yr = (a > 0) ? VEL_W'(cruise_speed) : -VEL_W'(cruise_speed);
    end
    c_side_next.neg  = {bst[N].bz < 0, bst[N].by < 0, bst[N].bx < 0};
    c_side_next.zero = bst[N].fin || (bst[N].mx == '0);
    c_side_next.fin  = bst[N].fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= bv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num[0] <= mags[0] * cruise_speed;
      c_num[1] <= mags[1] * cruise_speed;
      c_num[2] <= mags[2] * cruise_speed;
      c_mx     <= bst[N].mx;
      c_side   <= c_side_next;
    end
  end

  // scaling division
  logic                d_v;
  logic [2:0][Q_W-1:0] d_q;
  div_side_t           d_side;

  wvc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .num       (c_num),
    .mx        (c_mx),
    .side_in   (c_side),
    .out_valid (d_v),
    .quo       (d_q),
    .side_out  (d_side)
  );

  // output register
  logic [2:0][VEL_W-1:0] vel_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_side.zero) begin
        vel_next[l] = '0;
      end else if (d_side.neg[l]) begin
        vel_next[l] = -VEL_W'(d_q[l]);
      end else begin
        vel_next[l] = VEL_W'(d_q[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_x    <= vel_next[0];
      vel_y    <= vel_next[1];
      vel_z    <= vel_next[2];
      yaw_rate <= d_side.yr;
      finished <= d_side.fin;
    end
  end

  // checks
  `WVC_ASSERT(a_fin_zero, !(out_valid && finished) || (vel_x == '0 && vel_y == '0 && vel_z == '0))
  `WVC_ASSERT(a_yr_set, !out_valid || yaw_rate == '0 || yaw_rate == VEL_W'(cruise_speed) || yaw_rate == -VEL_W'(cruise_speed))
  `WVC_ASSERT_NEXT(a_out_src, en, out_valid == $past(d_v))
  `WVC_ASSERT_NEXT(a_hold, !en, out_valid)

endmodule
